>>> hw/rtl/iad_pkg.sv
// Package for the IMA ADPCM nibble decoder: step and index tables, limits.
`default_nettype none

package iad_pkg;

  localparam int unsigned StepIdxW = 7;
  localparam int unsigned StepW    = 15;
  localparam int unsigned SampleW  = 16;

  localparam logic [StepIdxW-1:0] StepIdxMax = 7'd88;

  // Predictor limits at the width of the widened sum.
  localparam logic signed [SampleW+1:0] PredMax = 18'sd32767;
  localparam logic signed [SampleW+1:0] PredMin = -18'sd32768;

  typedef logic [StepIdxW-1:0]       step_idx_t;
  typedef logic [StepW-1:0]          step_t;
  typedef logic signed [SampleW-1:0] sample_t;

  // IMA step size for a step index; indexes past the end read the last entry.
  function automatic step_t iad_step(input step_idx_t idx);
    step_t s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Step index adjustment for the three magnitude bits of a code.
  function automatic logic signed [StepIdxW:0] iad_adjust(input logic [2:0] mag);
    logic signed [StepIdxW:0] a;
    case (mag)
      3'd4:    a = 8'sd2;
      3'd5:    a = 8'sd4;
      3'd6:    a = 8'sd6;
      3'd7:    a = 8'sd8;
      default: a = -8'sd1;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ima_adpcm_nibble_decoder.sv
// Top level of the IMA ADPCM nibble decoder: one byte in, two samples out.
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ---------------------------------------
//   input    in         in_valid_i/in_stall_o  coded_byte_i[7:0]
//   output   out        out_valid_o/out_stall_i sample_o[15:0], channel_id_o, last_of_byte_o
//   config   in         cfg_we_i               cfg_wdata_i (stereo mode)
//
// The shared nibble decoder handles the high nibble of each accepted byte first
// and then the low nibble, writing each sample to the single output sample
// register. A new byte is accepted in the same cycle as the low nibble of the
// previous one is decoded. The first sample of a byte passes through the input
// register and then the output sample register.
// Reset clears both channel predictors and step indices and selects mono mode.
// A stall on the output only holds the sample register; the next nibble waits
// in the input register and the input stalls once that register is full.
`default_nettype none

module ima_adpcm_nibble_decoder
  import iad_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  coded_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output sample_t          sample_o,
  output logic             channel_id_o,
  output logic             last_of_byte_o
);

  // Stereo mode register.
  logic stereo_q;

  // Input register: the byte under decode and which nibble comes next.
  logic       in_valid_q;
  logic       phase_q;
  logic [7:0] byte_q;

  // Per-channel decoder state.
  sample_t   pred_q [2];
  step_idx_t idx_q  [2];

  // Output register.
  logic    out_valid_q;
  sample_t sample_q;
  logic    chan_q;
  logic    last_q;

  // Decode datapath.
  logic                      advance;
  logic                      accept_in;
  logic [3:0]                nib;
  logic                      ch;
  sample_t                   cur_pred;
  step_idx_t                 cur_idx;
  step_t                     step;
  logic [StepW+3:0]          prod;
  logic [SampleW-1:0]        diff;
  logic signed [SampleW+1:0] pred_ext;
  logic signed [SampleW+1:0] diff_ext;
  logic signed [SampleW+1:0] sum;
  sample_t                   pred_d;
  logic signed [StepIdxW:0]  idx_sum;
  step_idx_t                 idx_d;

  // A nibble is decoded whenever a byte is held and the output register is
  // free or being emptied in this cycle.
  assign advance   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !(advance && phase_q);
  assign accept_in = in_valid_i && !in_stall_o;

  // The high nibble always uses channel 0; the low nibble uses channel 1
  // only in stereo mode.
  assign nib      = phase_q ? byte_q[3:0] : byte_q[7:4];
  assign ch       = phase_q & stereo_q;
  assign cur_pred = pred_q[ch];
  assign cur_idx  = idx_q[ch];
  assign step     = iad_step(cur_idx);

  // Difference is floor((2*m + 1) * step / 8); the product is never negative.
  assign prod     = {15'd0, nib[2:0], 1'b1} * {4'd0, step};
  assign diff     = prod[StepW+3:3];
  assign pred_ext = {{2{cur_pred[SampleW-1]}}, cur_pred};
  assign diff_ext = {2'b00, diff};
  assign sum      = nib[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);

  always_comb begin
    if (sum > PredMax) begin
      pred_d = PredMax[SampleW-1:0];
    end else if (sum < PredMin) begin
      pred_d = PredMin[SampleW-1:0];
    end else begin
      pred_d = sum[SampleW-1:0];
    end
  end

  assign idx_sum = signed'({1'b0, cur_idx}) + iad_adjust(nib[2:0]);

  always_comb begin
    if (idx_sum < 0) begin
      idx_d = '0;
    end else if (idx_sum > signed'({1'b0, StepIdxMax})) begin
      idx_d = StepIdxMax;
    end else begin
      idx_d = idx_sum[StepIdxW-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q    <= 1'b0;
      in_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stereo_q <= cfg_wdata_i;
      end
      if (accept_in) begin
        in_valid_q <= 1'b1;
      end else if (advance && phase_q) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        phase_q <= ~phase_q;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Channel predictors and step indices.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q[0] <= '0;
      pred_q[1] <= '0;
      idx_q[0]  <= '0;
      idx_q[1]  <= '0;
    end else if (advance) begin
      pred_q[ch] <= pred_d;
      idx_q[ch]  <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      byte_q <= coded_byte_i;
    end
    if (advance) begin
      sample_q <= pred_d;
      chan_q   <= ch;
      last_q   <= phase_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;
  assign channel_id_o   = chan_q;
  assign last_of_byte_o = last_q;

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q[0] <= StepIdxMax) && (idx_q[1] <= StepIdxMax))
    else $error("step index out of range");

  a_first_on_ch0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_byte_o) |-> !channel_id_o)
    else $error("high nibble sample not on channel 0");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_byte_o && !out_stall_i) |=> (out_valid_o && last_of_byte_o))
    else $error("low nibble sample did not follow the high nibble sample");

  a_mono_ch1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stereo_q |=> ($stable(pred_q[1]) && $stable(idx_q[1])))
    else $error("channel 1 state changed in mono mode");

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");
`endif

endmodule

`default_nettype wire
